// ----- src/hdp_pkg.sv -----
`timescale 1ns / 1ps

package hdp_pkg;

    localparam int DEF_WIDTH_LOG2  = 8;
    localparam int DEF_HEIGHT_LOG2 = 8;
    localparam int DEF_DEPTH_BITS  = 24;

    localparam int COORD_BITS = 8;
    localparam int OUT_BITS   = 24;
    localparam int LEVEL_BITS = 4;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WBASE,
        ST_CHILD,
        ST_RCELL,
        ST_CMP,
        ST_QRD,
        ST_QCMP,
        ST_PRD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CHILD,
        RD_CELL,
        RD_PIX
    } rd_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_FIRST,
        ACC_NEXT
    } acc_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_BASE,
        WR_CELL,
        WR_CLEAR
    } wr_sel_t;

    typedef struct packed {
        logic                  load;
        rd_sel_t               rd;
        logic [1:0]            child;
        logic [LEVEL_BITS-1:0] lv;
        acc_t                  acc;
        wr_sel_t               wr;
        logic                  emit;
        logic                  vis;
        logic                  pix;
    } hdp_cmd_t;

    typedef struct packed {
        logic span;
        logic occl;
        logic min_eq;
        logic clr_last;
    } hdp_stat_t;

    function automatic int top_level(input int wl, input int hl);
        int m;
        m = (wl < hl) ? wl : hl;
        return (m > 2) ? m - 2 : 0;
    endfunction

    function automatic int coarse_cells(input int wl, input int hl);
        int n;
        int t;
        n = 0;
        t = top_level(wl, hl);
        for (int k = 1; k <= t; k++) begin
            n = n + (1 << (wl + hl - 2 * k));
        end
        return n;
    endfunction

endpackage

// ----- src/hdp_ctrl.sv -----
`timescale 1ns / 1ps

module hdp_ctrl #(
    parameter int WIDTH_LOG2  = hdp_pkg::DEF_WIDTH_LOG2,
    parameter int HEIGHT_LOG2 = hdp_pkg::DEF_HEIGHT_LOG2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    output logic              m_valid,
    input  logic              m_ready,
    output hdp_pkg::hdp_cmd_t cmd,
    input  hdp_pkg::hdp_stat_t stat
);
    import hdp_pkg::*;

    localparam logic [LEVEL_BITS-1:0] TOP_LV =
        LEVEL_BITS'(top_level(WIDTH_LOG2, HEIGHT_LOG2));

    state_t                state_reg, state_next;
    logic [1:0]            req_reg, req_next;
    logic [LEVEL_BITS-1:0] lv_reg, lv_next;
    logic [1:0]            ch_reg, ch_next;
    logic                  vis_reg, vis_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            req_reg     <= REQ_UPDATE;
            lv_reg      <= '0;
            ch_reg      <= '0;
            vis_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            lv_reg      <= lv_next;
            ch_reg      <= ch_next;
            vis_reg     <= vis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        lv_next      = lv_reg;
        ch_next      = ch_reg;
        vis_next     = vis_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.lv       = lv_reg;
        cmd.child    = ch_reg;
        cmd.vis      = vis_reg;
        cmd.pix      = (req_reg == REQ_READ);
        cmd.rd       = RD_NONE;
        cmd.acc      = ACC_NONE;
        cmd.wr       = WR_NONE;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr = WR_CLEAR;
                if (stat.clr_last) begin
                    state_next = (req_reg == REQ_CLEAR) ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    req_next = s_req_type;
                    vis_next = 1'b1;
                    case (s_req_type)
                        REQ_UPDATE: state_next = ST_WBASE;
                        REQ_QUERY: begin
                            lv_next    = TOP_LV;
                            state_next = (TOP_LV == '0) ? ST_DONE : ST_QRD;
                        end
                        REQ_READ: state_next = ST_PRD;
                        default: state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_WBASE: begin
                cmd.wr  = WR_BASE;
                lv_next = LEVEL_BITS'(1);
                ch_next = '0;
                state_next = (TOP_LV == '0) ? ST_DONE : ST_CHILD;
            end
            ST_CHILD: begin
                cmd.rd  = RD_CHILD;
                cmd.acc = (ch_reg == 2'd0) ? ACC_NONE :
                          (ch_reg == 2'd1) ? ACC_FIRST : ACC_NEXT;
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd3) begin
                    state_next = ST_RCELL;
                end
            end
            ST_RCELL: begin
                cmd.rd     = RD_CELL;
                cmd.acc    = ACC_NEXT;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (stat.min_eq) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.wr = WR_CELL;
                    if (lv_reg == TOP_LV) begin
                        state_next = ST_DONE;
                    end else begin
                        lv_next    = lv_reg + LEVEL_BITS'(1);
                        ch_next    = '0;
                        state_next = ST_CHILD;
                    end
                end
            end
            ST_QRD: begin
                if (stat.span) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd     = RD_CELL;
                    state_next = ST_QCMP;
                end
            end
            ST_QCMP: begin
                if (stat.occl) begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (lv_reg == LEVEL_BITS'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    lv_next    = lv_reg - LEVEL_BITS'(1);
                    state_next = ST_QRD;
                end
            end
            ST_PRD: begin
                cmd.rd     = RD_PIX;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("result not presented after emit");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHILD || state_reg == ST_QRD || state_reg == ST_CMP)
            |-> (lv_reg >= LEVEL_BITS'(1) && lv_reg <= TOP_LV))
        else $error("pyramid level out of range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("transaction accepted without starting work");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while pending");

endmodule

// ----- src/hdp_datapath.sv -----
`timescale 1ns / 1ps

module hdp_datapath #(
    parameter int WIDTH_LOG2  = hdp_pkg::DEF_WIDTH_LOG2,
    parameter int HEIGHT_LOG2 = hdp_pkg::DEF_HEIGHT_LOG2,
    parameter int DEPTH_BITS  = hdp_pkg::DEF_DEPTH_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [hdp_pkg::COORD_BITS-1:0]    s_x_lo,
    input  logic [hdp_pkg::COORD_BITS-1:0]    s_y_lo,
    input  logic [hdp_pkg::COORD_BITS-1:0]    s_x_hi,
    input  logic [hdp_pkg::COORD_BITS-1:0]    s_y_hi,
    input  logic signed [hdp_pkg::OUT_BITS-1:0] s_depth,
    output logic                              m_visible,
    output logic signed [hdp_pkg::OUT_BITS-1:0] m_read_depth,
    input  hdp_pkg::hdp_cmd_t                 cmd,
    output hdp_pkg::hdp_stat_t                stat
);
    import hdp_pkg::*;

    localparam int WL  = WIDTH_LOG2;
    localparam int HL  = HEIGHT_LOG2;
    localparam int AW  = WL + HL;
    localparam int TOP = top_level(WL, HL);
    localparam int CC  = coarse_cells(WL, HL);
    localparam int CCN = (CC < 1) ? 1 : CC;
    localparam int CAW = (CCN < 2) ? 1 : $clog2(CCN);
    localparam logic signed [DEPTH_BITS-1:0] FAR = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    logic [DEPTH_BITS-1:0] base_mem [0:(2**AW)-1];
    logic [DEPTH_BITS-1:0] coarse_mem [0:CCN-1];

    logic [WL-1:0]                xl_reg, xh_reg;
    logic [HL-1:0]                yl_reg, yh_reg;
    logic signed [DEPTH_BITS-1:0] z_reg, min_reg;
    logic signed [DEPTH_BITS-1:0] base_q_reg, coarse_q_reg;
    logic                         sel_base_reg;
    logic [AW-1:0]                clr_cnt_reg;
    logic                         out_vis_reg;
    logic signed [OUT_BITS-1:0]   out_rd_reg;

    logic signed [DEPTH_BITS-1:0] rd_q;
    logic [WL-1:0]                sx, ex, cx;
    logic [HL-1:0]                sy, ey, cy;
    logic [LEVEL_BITS-1:0]        clv;
    logic                         rd_en, rd_is_base;
    logic [AW-1:0]                rd_base_addr;
    logic [CAW-1:0]               rd_coarse_addr;
    logic                         base_we, coarse_we;
    logic [AW-1:0]                base_waddr;
    logic [CAW-1:0]               coarse_waddr;
    logic [DEPTH_BITS-1:0]        base_wdata, coarse_wdata;

    function automatic logic [AW-1:0] cell_addr(input logic [LEVEL_BITS-1:0] lv,
                                                input logic [WL-1:0] ax,
                                                input logic [HL-1:0] ay);
        logic [AW-1:0] off;
        logic [4:0]    sh;
        off = '0;
        sh  = 5'(WL) - 5'(lv);
        for (int k = 1; k <= TOP; k++) begin
            if (LEVEL_BITS'(k) < lv) begin
                off[AW-2*k] = 1'b1;
            end
        end
        return off + (AW'(ay) << sh) + AW'(ax);
    endfunction

    assign rd_q = sel_base_reg ? base_q_reg : coarse_q_reg;

    always_comb begin
        sx  = xl_reg >> cmd.lv;
        sy  = yl_reg >> cmd.lv;
        ex  = xh_reg >> cmd.lv;
        ey  = yh_reg >> cmd.lv;
        clv = cmd.lv - LEVEL_BITS'(1);
        cx  = (sx << 1) | WL'(cmd.child[0]);
        cy  = (sy << 1) | HL'(cmd.child[1]);

        rd_en          = 1'b0;
        rd_is_base     = 1'b0;
        rd_base_addr   = cell_addr('0, xl_reg, yl_reg);
        rd_coarse_addr = CAW'(cell_addr(cmd.lv, sx, sy));
        case (cmd.rd)
            RD_CHILD: begin
                rd_en      = 1'b1;
                rd_is_base = (clv == '0);
                rd_base_addr   = cell_addr('0, cx, cy);
                rd_coarse_addr = CAW'(cell_addr(clv, cx, cy));
            end
            RD_CELL: rd_en = 1'b1;
            RD_PIX: begin
                rd_en      = 1'b1;
                rd_is_base = 1'b1;
            end
            default: rd_en = 1'b0;
        endcase

        base_we      = (cmd.wr == WR_BASE) || (cmd.wr == WR_CLEAR);
        base_waddr   = (cmd.wr == WR_CLEAR) ? clr_cnt_reg : cell_addr('0, xl_reg, yl_reg);
        base_wdata   = (cmd.wr == WR_CLEAR) ? FAR : z_reg;
        coarse_we    = (cmd.wr == WR_CELL) ||
                       ((cmd.wr == WR_CLEAR) && (clr_cnt_reg < AW'(CCN)));
        coarse_waddr = (cmd.wr == WR_CLEAR) ? CAW'(clr_cnt_reg) : CAW'(cell_addr(cmd.lv, sx, sy));
        coarse_wdata = (cmd.wr == WR_CLEAR) ? FAR : min_reg;
    end

    always_ff @(posedge aclk) begin
        if (base_we) begin
            base_mem[base_waddr] <= base_wdata;
        end
        if (!aresetn) begin
            base_q_reg <= '0;
        end else if (rd_en && rd_is_base) begin
            base_q_reg <= base_mem[rd_base_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (coarse_we) begin
            coarse_mem[coarse_waddr] <= coarse_wdata;
        end
        if (!aresetn) begin
            coarse_q_reg <= '0;
        end else if (rd_en && !rd_is_base) begin
            coarse_q_reg <= coarse_mem[rd_coarse_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.wr == WR_CLEAR) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_base_reg <= 1'b0;
        end else if (rd_en) begin
            sel_base_reg <= rd_is_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            xl_reg <= WL'(s_x_lo);
            yl_reg <= HL'(s_y_lo);
            xh_reg <= WL'(s_x_hi);
            yh_reg <= HL'(s_y_hi);
            z_reg  <= DEPTH_BITS'($unsigned(s_depth));
        end
        case (cmd.acc)
            ACC_FIRST: min_reg <= rd_q;
            ACC_NEXT: if (rd_q < min_reg) min_reg <= rd_q;
            default: min_reg <= min_reg;
        endcase
        if (cmd.emit) begin
            out_vis_reg <= cmd.vis;
            out_rd_reg  <= cmd.pix ? OUT_BITS'(rd_q) : '0;
        end
    end

    assign stat.span     = (sx != ex) || (sy != ey);
    assign stat.occl     = z_reg < rd_q;
    assign stat.min_eq   = (rd_q == min_reg);
    assign stat.clr_last = &clr_cnt_reg;

    assign m_visible    = out_vis_reg;
    assign m_read_depth = out_rd_reg;

    a_clear_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr == WR_CLEAR) |=> clr_cnt_reg == $past(clr_cnt_reg) + AW'(1))
        else $error("clear sweep skipped an entry");

    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd == RD_NONE && cmd.acc == ACC_NONE && !cmd.load) |=> $stable(rd_q))
        else $error("read data changed without a read");

    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr == WR_CLEAR && cmd.rd != RD_NONE))
        else $error("read issued during clear sweep");

endmodule

// ----- src/hierarchical_depth_pyramid.sv -----
`timescale 1ns / 1ps
// Channel  Handshake          Payload
// s_       s_valid/s_ready    s_req_type, s_x_lo, s_y_lo, s_x_hi, s_y_hi, s_depth
// m_       m_valid/m_ready    m_visible, m_read_depth
//
// Update: writes the base cell, then walks up the pyramid level by level (up to min log2 - 2 levels);
//   each level reads four children and then the parent, one read at a time.
// Query: walks down from the top level, reading one cell per level. Read: returns one base depth.
// Clear request and reset: sweep over all 2^(WIDTH_LOG2+HEIGHT_LOG2) base entries, no input taken.
// One transaction in flight; the next is taken while a result waits in the output register.
module hierarchical_depth_pyramid #(
    parameter int WIDTH_LOG2  = hdp_pkg::DEF_WIDTH_LOG2,
    parameter int HEIGHT_LOG2 = hdp_pkg::DEF_HEIGHT_LOG2,
    parameter int DEPTH_BITS  = hdp_pkg::DEF_DEPTH_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [hdp_pkg::COORD_BITS-1:0]      s_x_lo,
    input  logic [hdp_pkg::COORD_BITS-1:0]      s_y_lo,
    input  logic [hdp_pkg::COORD_BITS-1:0]      s_x_hi,
    input  logic [hdp_pkg::COORD_BITS-1:0]      s_y_hi,
    input  logic signed [hdp_pkg::OUT_BITS-1:0] s_depth,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible,
    output logic signed [hdp_pkg::OUT_BITS-1:0] m_read_depth
);
    import hdp_pkg::*;

    hdp_cmd_t  cmd;
    hdp_stat_t stat;

    hdp_ctrl #(
        .WIDTH_LOG2 (WIDTH_LOG2),
        .HEIGHT_LOG2(HEIGHT_LOG2)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req_type(s_req_type),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hdp_datapath #(
        .WIDTH_LOG2 (WIDTH_LOG2),
        .HEIGHT_LOG2(HEIGHT_LOG2),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_x_lo      (s_x_lo),
        .s_y_lo      (s_y_lo),
        .s_x_hi      (s_x_hi),
        .s_y_hi      (s_y_hi),
        .s_depth     (s_depth),
        .m_visible   (m_visible),
        .m_read_depth(m_read_depth),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
